>>> src/uwma_pkg.sv
// uwma_pkg: types, sizes and byte-merge helpers for the unaligned word port
// used by unaligned_word_memory_access and its checker; depends on nothing
package uwma_pkg;

  localparam int MEM_BYTES   = 16384;
  localparam int ADDR_W      = 14;
  localparam int DATA_W      = 32;
  localparam int STORE_WORDS = MEM_BYTES / 4;
  localparam int BANK_DEPTH  = (STORE_WORDS + 1) / 2;
  localparam int BANK_AW     = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
  localparam int LIMIT_W     = 22;
  localparam logic [LIMIT_W-1:0] StoreLimit = LIMIT_W'(4 * STORE_WORDS);

  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  typedef struct packed {
    logic              operation;
    logic [ADDR_W-1:0] address;
    logic [DATA_W-1:0] write_data;
  } req_t;

  typedef struct packed {
    logic [DATA_W-1:0] read_data;
    logic              out_of_range;
  } rsp_t;

  // last byte of the access at or past the end of the store
  function automatic logic is_bad(input logic [ADDR_W-1:0] addr);
    return (LIMIT_W'(addr) + LIMIT_W'(3)) >= StoreLimit;
  endfunction

  // mask of the low r bytes, r in 0..3
  function automatic logic [DATA_W-1:0] low_mask(input logic [1:0] r);
    logic [DATA_W-1:0] m;
    unique case (r)
      2'd0:    m = 32'h0000_0000;
      2'd1:    m = 32'h0000_00ff;
      2'd2:    m = 32'h0000_ffff;
      2'd3:    m = 32'h00ff_ffff;
      default: m = 32'h0000_0000;
    endcase
    return m;
  endfunction

  // lo is word q, hi is word q+1
  function automatic logic [DATA_W-1:0] load_merge(input logic [DATA_W-1:0] lo,
                                                   input logic [DATA_W-1:0] hi,
                                                   input logic [1:0]        r);
    logic [4:0] sh_lo;
    logic [5:0] sh_hi;
    sh_lo = {r, 3'b000};
    sh_hi = 6'd32 - {1'b0, r, 3'b000};
    if (r == 2'd0) begin
      return lo;
    end
    return (lo >> sh_lo) | (hi << sh_hi);
  endfunction

  function automatic logic [DATA_W-1:0] store_lo(input logic [DATA_W-1:0] lo,
                                                 input logic [DATA_W-1:0] data,
                                                 input logic [1:0]        r);
    logic [4:0] sh;
    sh = {r, 3'b000};
    return (lo & low_mask(r)) | (data << sh);
  endfunction

  function automatic logic [DATA_W-1:0] store_hi(input logic [DATA_W-1:0] hi,
                                                 input logic [DATA_W-1:0] data,
                                                 input logic [1:0]        r);
    logic [5:0] sh;
    sh = 6'd32 - {1'b0, r, 3'b000};
    return (hi & ~low_mask(r)) | (data >> sh);
  endfunction

endpackage

>>> src/unaligned_word_memory_access.sv
// unaligned_word_memory_access: little-endian word load/store at any byte address
// a taken word goes through the exec state and then the result register to done_o;
// busy holds off new words in exec (read both banks, then merge and write back)
// reset: asynchronous active low; then a clearing pass over BANK_DEPTH rows
// (2048 at 16384 bytes) zeroes both banks while busy stays high
// the receiver cannot stall: each result shows for exactly one cycle on done_o
module unaligned_word_memory_access
  import uwma_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  req_t req_i,
  output rsp_t rsp_o,
  output logic done_o
);

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_EXEC  = 2'd2;

  logic [1:0] state_q, state_d;
  logic [BANK_AW-1:0] clr_q, clr_d;

  // even words live in one bank, odd words in the other, so words q and q+1
  // are always in different banks and both come out in the same cycle
  logic [DATA_W-1:0] even_mem [BANK_DEPTH];
  logic [DATA_W-1:0] odd_mem  [BANK_DEPTH];
  logic [DATA_W-1:0] even_rd_q, odd_rd_q;

  logic              even_we, odd_we;
  logic [BANK_AW-1:0] even_waddr, odd_waddr;
  logic [DATA_W-1:0] even_wdata, odd_wdata;

  // captured word request
  req_t              req_q;
  logic              bad_q;
  logic [BANK_AW-1:0] even_idx_q, odd_idx_q;

  logic              accept;
  logic [ADDR_W-3:0] word_idx;
  logic [BANK_AW-1:0] even_idx, odd_idx;

  // merge datapath
  logic              lo_odd;
  logic [1:0]        offs;
  logic [DATA_W-1:0] lo_word, hi_word, new_lo, new_hi, load_val;
  logic              wr_go, wr_hi;

  rsp_t rsp_q, rsp_d;
  logic done_q, done_d;

  assign busy   = (state_q != ST_IDLE);
  assign accept = start && !busy;

  // word q in the even bank at q/2 and q+1 in the odd bank at q/2, or
  // q in the odd bank at q/2 and q+1 in the even bank at q/2+1
  assign word_idx = req_i.address[ADDR_W-1:2];
  assign odd_idx  = BANK_AW'(word_idx[ADDR_W-3:1]);
  assign even_idx = BANK_AW'(word_idx[ADDR_W-3:1]) + BANK_AW'(word_idx[0]);

  // control
  always_comb begin
    state_d = state_q;
    clr_d   = clr_q;
    unique case (state_q)
      ST_CLEAR: begin
        clr_d = clr_q + BANK_AW'(1);
        if (clr_q == BANK_AW'(BANK_DEPTH - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      done_q  <= done_d;
    end
  end

  // request capture, no reset needed on payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q      <= req_i;
      bad_q      <= is_bad(req_i.address);
      even_idx_q <= even_idx;
      odd_idx_q  <= odd_idx;
    end
    rsp_q <= rsp_d;
  end

  // merge and write back in the exec cycle
  assign lo_odd  = req_q.address[2];
  assign offs    = req_q.address[1:0];
  assign lo_word = lo_odd ? odd_rd_q  : even_rd_q;
  assign hi_word = lo_odd ? even_rd_q : odd_rd_q;

  assign load_val = load_merge(lo_word, hi_word, offs);
  assign new_lo   = store_lo(lo_word, req_q.write_data, offs);
  assign new_hi   = store_hi(hi_word, req_q.write_data, offs);

  assign wr_go = (state_q == ST_EXEC) && (req_q.operation == OP_WRITE) && !bad_q;
  assign wr_hi = (offs != 2'd0);

  always_comb begin
    even_we    = 1'b0;
    odd_we     = 1'b0;
    even_waddr = even_idx_q;
    odd_waddr  = odd_idx_q;
    even_wdata = lo_odd ? new_hi : new_lo;
    odd_wdata  = lo_odd ? new_lo : new_hi;
    if (state_q == ST_CLEAR) begin
      // zero one row of both banks a cycle
      even_we    = 1'b1;
      odd_we     = 1'b1;
      even_waddr = clr_q;
      odd_waddr  = clr_q;
      even_wdata = '0;
      odd_wdata  = '0;
    end else if (wr_go) begin
      even_we = lo_odd ? wr_hi : 1'b1;
      odd_we  = lo_odd ? 1'b1  : wr_hi;
    end
  end

  // result register
  always_comb begin
    done_d             = (state_q == ST_EXEC);
    rsp_d.out_of_range = bad_q;
    rsp_d.read_data    = ((req_q.operation == OP_READ) && !bad_q) ? load_val : '0;
  end

  // bank ports: reads issue at accept, writes land in exec; busy keeps the
  // two apart so no read of an entry overlaps its write back
  always_ff @(posedge clk_i) begin
    if (even_we) begin
      even_mem[even_waddr] <= even_wdata;
    end
    if (accept) begin
      even_rd_q <= even_mem[even_idx];
    end
  end

  always_ff @(posedge clk_i) begin
    if (odd_we) begin
      odd_mem[odd_waddr] <= odd_wdata;
    end
    if (accept) begin
      odd_rd_q <= odd_mem[odd_idx];
    end
  end

  assign rsp_o  = rsp_q;
  assign done_o = done_q;

endmodule

>>> src/uwma_checker.sv
// uwma_checker: port-level assertions for unaligned_word_memory_access
// depends on uwma_pkg; attached to the top level by the bind at the end
module uwma_checker
  import uwma_pkg::*;
(
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input req_t req_i,
  input rsp_t rsp_o,
  input logic done_o
);

  // every result follows a taken word through the exec state and the result register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy, 2))
    else $error("result without a taken word two cycles earlier");

  // a taken word holds the port busy for its merge cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("not busy after taking a word");

  // a write never returns data
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && ($past(req_i.operation, 2) == OP_WRITE)) |-> (rsp_o.read_data == '0))
    else $error("write returned nonzero data");

  // range flag follows the address of the taken word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (rsp_o.out_of_range == is_bad($past(req_i.address, 2))))
    else $error("range flag does not match address");

  // out of range reads answer zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && rsp_o.out_of_range) |-> (rsp_o.read_data == '0))
    else $error("out of range access returned data");

endmodule

bind unaligned_word_memory_access uwma_checker u_uwma_checker (.*);

>>> dv/tb_unaligned_word_memory_access.sv
// tb_unaligned_word_memory_access: self-checking bench for the unaligned word load/store port
// depends on uwma_pkg (req_t, rsp_t, sizes, operation codes) and unaligned_word_memory_access
module tb_unaligned_word_memory_access
  import uwma_pkg::*;
;

  // one row of the directed table; typed rows carry their own answer
  typedef struct {
    req_t word;
    bit   typed;
    rsp_t want;
  } plan_row_t;

  localparam int PlanRows   = 25;
  localparam int RandWords  = 1300;
  localparam int QuietFirst = PlanRows + 400;
  localparam int QuietLast  = PlanRows + 750;
  localparam int TopBytes   = STORE_WORDS * 4;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  logic start;
  logic busy;
  req_t req_i;
  rsp_t rsp_o;
  logic done_o;

  // byte-wide shadow of the store, cleared like the block after reset
  logic [7:0] shadow_bytes [TopBytes];
  rsp_t       awaited_rsps [$];
  int         mismatches = 0;

  unaligned_word_memory_access DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .req_i  (req_i),
    .rsp_o  (rsp_o),
    .done_o (done_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // runs one access against the shadow and returns the answer the block owes
  function automatic rsp_t shadow_access(input req_t w);
    rsp_t        r;
    int unsigned a;
    r = '0;
    a = 32'(w.address);
    // the access is bad when its last byte reaches the end of the store
    r.out_of_range = (a + 3) >= TopBytes;
    if (!r.out_of_range) begin
      for (int i = 0; i < 4; i++) begin
        if (w.operation == OP_WRITE) begin
          shadow_bytes[a + i] = w.write_data[8*i +: 8];
        end else begin
          r.read_data[8*i +: 8] = shadow_bytes[a + i];
        end
      end
    end
    return r;
  endfunction

  function automatic plan_row_t row(input logic op, input int addr, input logic [31:0] data,
                                    input bit typed, input logic [31:0] rd, input logic bad);
    plan_row_t p;
    p.word.operation  = op;
    p.word.address    = ADDR_W'(addr);
    p.word.write_data = data;
    p.typed           = typed;
    p.want.read_data  = rd;
    p.want.out_of_range = bad;
    return p;
  endfunction

  // directed table: store ends, first bad address, each byte offset, both operations
  function automatic plan_row_t plan_entry(input int n);
    plan_row_t p;
    case (n)
      // fresh store reads zero, the top addresses are out of range
      0:  p = row(OP_READ,  0,     32'h0000_0000, 1, 32'h0, 1'b0);
      1:  p = row(OP_READ,  16383, 32'hffff_ffff, 1, 32'h0, 1'b1);
      2:  p = row(OP_READ,  16381, 32'h0000_0000, 1, 32'h0, 1'b1);
      3:  p = row(OP_READ,  16380, 32'h0000_0000, 1, 32'h0, 1'b0);
      // a bad write answers zero and leaves the store alone
      4:  p = row(OP_WRITE, 16382, 32'hffff_ffff, 1, 32'h0, 1'b1);
      5:  p = row(OP_WRITE, 0,     32'h0403_0201, 1, 32'h0, 1'b0);
      6:  p = row(OP_READ,  0,     32'h0,         0, 32'h0, 1'b0);
      7:  p = row(OP_READ,  1,     32'h0,         0, 32'h0, 1'b0);
      8:  p = row(OP_READ,  2,     32'h0,         0, 32'h0, 1'b0);
      9:  p = row(OP_READ,  3,     32'h0,         0, 32'h0, 1'b0);
      // unaligned writes split across two words
      10: p = row(OP_WRITE, 5,     32'hffff_ffff, 1, 32'h0, 1'b0);
      11: p = row(OP_READ,  4,     32'h0,         0, 32'h0, 1'b0);
      12: p = row(OP_READ,  8,     32'h0,         0, 32'h0, 1'b0);
      13: p = row(OP_WRITE, 10,    32'ha1b2_c3d4, 1, 32'h0, 1'b0);
      14: p = row(OP_READ,  8,     32'h0,         0, 32'h0, 1'b0);
      15: p = row(OP_READ,  12,    32'h0,         0, 32'h0, 1'b0);
      16: p = row(OP_READ,  10,    32'h0,         0, 32'h0, 1'b0);
      // last good word of the store
      17: p = row(OP_WRITE, 16380, 32'hffff_ffff, 1, 32'h0, 1'b0);
      18: p = row(OP_READ,  16380, 32'h0,         1, 32'hffff_ffff, 1'b0);
      19: p = row(OP_WRITE, 16379, 32'h0000_0000, 1, 32'h0, 1'b0);
      20: p = row(OP_READ,  16377, 32'h0,         0, 32'h0, 1'b0);
      21: p = row(OP_READ,  16383, 32'h0,         1, 32'h0, 1'b1);
      22: p = row(OP_WRITE, 3,     32'h0000_0000, 1, 32'h0, 1'b0);
      23: p = row(OP_READ,  0,     32'h0,         0, 32'h0, 1'b0);
      default: p = row(OP_WRITE, 16383, 32'ha5a5_a5a5, 1, 32'h0, 1'b1);
    endcase
    return p;
  endfunction

  // random words crowd the bottom and top of the store so that accesses overlap,
  // the rest spread over the whole address range
  function automatic req_t random_word();
    req_t        w;
    int unsigned pick;
    pick = $urandom_range(99);
    w.operation  = 1'($urandom_range(1));
    w.write_data = $urandom();
    if (pick < 40) begin
      w.address = ADDR_W'($urandom_range(63));
    end else if (pick < 70) begin
      w.address = ADDR_W'(TopBytes - 64 + $urandom_range(63));
    end else begin
      w.address = ADDR_W'($urandom());
    end
    return w;
  endfunction

  // stimulus: reset, directed table, then random words
  initial begin
    plan_row_t p;
    rsp_t      got;
    bit        quiet;
    start <= 1'b0;
    req_i <= '0;
    foreach (shadow_bytes[k]) shadow_bytes[k] = 8'h00;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (int n = 0; n < PlanRows + RandWords; n++) begin
      if (n < PlanRows) begin
        p = plan_entry(n);
      end else begin
        p.word  = random_word();
        p.typed = 1'b0;
        p.want  = '0;
      end
      // random gaps before a word, none inside the long quiet stretch
      quiet = (n >= QuietFirst) && (n < QuietLast);
      while (!quiet && $urandom_range(99) < 30) begin
        start <= 1'b0;
        @(posedge clk_i);
      end
      start <= 1'b1;
      req_i <= p.word;
      @(posedge clk_i);
      // covers the clearing pass after reset as well as the exec state of the access
      while (busy) @(posedge clk_i);
      // word taken at this edge; the shadow moves even for typed rows
      got = shadow_access(p.word);
      awaited_rsps.push_back(p.typed ? p.want : got);
    end
    start <= 1'b0;
    while (awaited_rsps.size() != 0) @(posedge clk_i);
    // let a stray late strobe show up before the verdict
    repeat (6) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // result checker: every strobe must meet the oldest expectation
  always @(posedge clk_i) begin
    rsp_t want;
    if (rst_ni && done_o) begin
      if (awaited_rsps.size() == 0) begin
        $display("%0t unexpected result: read_data %h out_of_range %b", $time,
                 rsp_o.read_data, rsp_o.out_of_range);
        mismatches++;
      end else begin
        want = awaited_rsps.pop_front();
        if (rsp_o.read_data !== want.read_data) begin
          $display("%0t read_data expected %h actual %h", $time,
                   want.read_data, rsp_o.read_data);
          mismatches++;
        end
        if (rsp_o.out_of_range !== want.out_of_range) begin
          $display("%0t out_of_range expected %b actual %b", $time,
                   want.out_of_range, rsp_o.out_of_range);
          mismatches++;
        end
      end
    end
  end

  // watchdog: clearing pass plus every word with its gaps, many times over
  initial begin
    #4000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

>>> unaligned_word_memory_access.f
src/uwma_pkg.sv
src/unaligned_word_memory_access.sv
src/uwma_checker.sv
dv/tb_unaligned_word_memory_access.sv
